/* design/triangle_facet_normal_unit_top_macros.svh */
// triangle_facet_normal_unit_top_macros.svh: assertion macros for the facet normal unit
// no dependencies; included by the checker
`ifndef TRIANGLE_FACET_NORMAL_UNIT_TOP_MACROS_SVH
`define TRIANGLE_FACET_NORMAL_UNIT_TOP_MACROS_SVH

// same-cycle implication
`define TFN_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TFN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/tfn_pkg.sv */
// tfn_pkg: shared types of the facet normal unit
// no dependencies; used by the cell modules and the top level
package tfn_pkg;

   // per-cell control: hold enable and incoming valid
   typedef struct packed {
      logic en;
      logic vld;
   } ctl_type;

endpackage

/* design/tfn_sqrt_cell.sv */
// tfn_sqrt_cell: one digit of the pipelined floor square root
// depends on tfn_pkg
module tfn_sqrt_cell #(
   parameter int RW     = 35,
   parameter int SIDE_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tfn_pkg::ctl_type     ctl,
   input  logic [2*RW-1:0]      rad_in,
   input  logic [RW+1:0]        rem_in,
   input  logic [RW-1:0]        root_in,
   input  logic [SIDE_W-1:0]    side_in,
   output logic                 vld_out,
   output logic [2*RW-1:0]      rad_out,
   output logic [RW+1:0]        rem_out,
   output logic [RW-1:0]        root_out,
   output logic [SIDE_W-1:0]    side_out
);
   import tfn_pkg::*;

   logic                vld_ff;
   logic [2*RW-1:0]     rad_ff;
   logic [RW+1:0]       rem_ff, rem_in_t, trial, rem_next;
   logic [RW-1:0]       root_ff, root_next;
   logic [SIDE_W-1:0]   side_ff;

   // bring down the next two radicand bits and try root*4+1
   assign rem_in_t = {rem_in[RW-1:0], rad_in[2*RW-1 -: 2]};
   assign trial    = {root_in, 2'b01};

   always_comb begin
      if (rem_in_t >= trial) begin
         rem_next  = rem_in_t - trial;
         root_next = {root_in[RW-2:0], 1'b1};
      end else begin
         rem_next  = rem_in_t;
         root_next = {root_in[RW-2:0], 1'b0};
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (ctl.en) begin
         vld_ff <= ctl.vld;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ctl.en) begin
         rad_ff  <= {rad_in[2*RW-3:0], 2'b00};
         rem_ff  <= rem_next;
         root_ff <= root_next;
         side_ff <= side_in;
      end
   end

   assign vld_out  = vld_ff;
   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign side_out = side_ff;

endmodule

/* design/tfn_div_cell.sv */
// tfn_div_cell: one quotient bit of three restoring dividers sharing a divisor
// depends on tfn_pkg
module tfn_div_cell #(
   parameter int RW     = 35,
   parameter int QW     = 15,
   parameter int SIDE_W = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tfn_pkg::ctl_type     ctl,
   input  logic [RW-1:0]        div_in,
   input  logic [2:0][RW:0]     r_in,
   input  logic [2:0][QW-1:0]   q_in,
   input  logic [SIDE_W-1:0]    side_in,
   output logic                 vld_out,
   output logic [RW-1:0]        div_out,
   output logic [2:0][RW:0]     r_out,
   output logic [2:0][QW-1:0]   q_out,
   output logic [SIDE_W-1:0]    side_out
);
   import tfn_pkg::*;

   logic                vld_ff;
   logic [RW-1:0]       div_ff;
   logic [2:0][RW:0]    r_ff, r_next;
   logic [2:0][QW-1:0]  q_ff, q_next;
   logic [SIDE_W-1:0]   side_ff;
   logic [2:0][RW:0]    r_sub;
   logic [2:0]          ge;

   // compare, subtract, shift for each lane
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ge[k]     = r_in[k] >= {1'b0, div_in};
         r_sub[k]  = ge[k] ? (r_in[k] - {1'b0, div_in}) : r_in[k];
         r_next[k] = {r_sub[k][RW-1:0], 1'b0};
         q_next[k] = {q_in[k][QW-2:0], ge[k]};
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (ctl.en) begin
         vld_ff <= ctl.vld;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ctl.en) begin
         div_ff  <= div_in;
         r_ff    <= r_next;
         q_ff    <= q_next;
         side_ff <= side_in;
      end
   end

   assign vld_out  = vld_ff;
   assign div_out  = div_ff;
   assign r_out    = r_ff;
   assign q_out    = q_ff;
   assign side_out = side_ff;

endmodule

/* design/triangle_facet_normal_unit_top.sv */
// triangle_facet_normal_unit_top: unit face normal of one triangle
// Takes three signed Q8.8 vertices per transfer on the req_ channel and returns a
// signed Q1.14 unit normal plus a degenerate flag per transfer on the rsp_ channel.
// A transfer happens at a rising edge with valid high and stall low.
// Pipeline: five front stages (edges, products, cross, squares, sum), one cell per root bit
// of the square root chain (2*COORD_BITS+3), one cell per quotient bit of the
// divider chain (NORMAL_FRAC_BITS+1) and the output register.
// Throughput: one triangle per cycle while req_stall is low; every cell hands its
// item on each cycle in which the chain is not held.
// Stall: the output register is backed by one skid entry, so when rsp_stall rises
// the pipeline keeps taking one more result; once the skid entry fills the whole
// chain holds and req_stall is high until the skid entry drains.
// Reset (synchronous, active high) empties the pipeline; no result is pending after.
// A zero-length cross product gives a zero normal with rsp_degenerate set.
// Depends on tfn_pkg, tfn_sqrt_cell and tfn_div_cell.
module triangle_facet_normal_unit_top #(
   parameter int COORD_BITS       = 16,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [COORD_BITS-1:0]      req_v0_x,
   input  logic signed [COORD_BITS-1:0]      req_v0_y,
   input  logic signed [COORD_BITS-1:0]      req_v0_z,
   input  logic signed [COORD_BITS-1:0]      req_v1_x,
   input  logic signed [COORD_BITS-1:0]      req_v1_y,
   input  logic signed [COORD_BITS-1:0]      req_v1_z,
   input  logic signed [COORD_BITS-1:0]      req_v2_x,
   input  logic signed [COORD_BITS-1:0]      req_v2_y,
   input  logic signed [COORD_BITS-1:0]      req_v2_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_x,
   output logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_y,
   output logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_z,
   output logic                              rsp_degenerate
);
   import tfn_pkg::*;

   localparam int DW     = COORD_BITS + 1;
   localparam int PW     = 2 * DW;
   localparam int MW     = PW;
   localparam int RW     = MW + 1;
   localparam int SW     = 2 * RW;
   localparam int QW     = NORMAL_FRAC_BITS + 1;
   localparam int OW     = NORMAL_FRAC_BITS + 2;
   localparam int SQ_SIDE = 3 * MW + 4;
   localparam int DV_SIDE = 4;
   localparam int RES_W  = 3 * OW + 1;

   logic en;

   // front stage registers
   logic [4:0]               fv_ff;
   logic signed [DW-1:0]     ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   logic signed [PW-1:0]     prod_ff [6];
   logic [MW-1:0]            mag3_ff [3], mag4_ff [3];
   logic [2:0]               neg3_ff, neg4_ff, neg5_ff;
   logic [2*MW-1:0]          sq_ff [3];
   logic [SW-1:0]            sum_ff;
   logic [MW-1:0]            mag5_ff [3];
   logic                     deg5_ff;
   logic signed [PW:0]       cross_w [3];
   logic signed [PW:0]       cross_neg_w [3];

   // skid stage
   logic                     out_vld_ff, skid_vld_ff;
   logic [RES_W-1:0]         out_ff, skid_ff, last_res;

   // pipeline holds only while the skid entry is occupied
   assign en        = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   // front valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (en) begin
         fv_ff <= {fv_ff[3:0], req_valid};
      end
   end

   // cross product terms, signed with one guard bit
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cross_w[k]     = (PW+1)'(prod_ff[2*k]) - (PW+1)'(prod_ff[2*k+1]);
         cross_neg_w[k] = -cross_w[k];
      end
   end

   // edges, products, cross magnitudes, squares, sum
   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= DW'(req_v1_x) - DW'(req_v0_x);
         ay_ff <= DW'(req_v1_y) - DW'(req_v0_y);
         az_ff <= DW'(req_v1_z) - DW'(req_v0_z);
         bx_ff <= DW'(req_v2_x) - DW'(req_v0_x);
         by_ff <= DW'(req_v2_y) - DW'(req_v0_y);
         bz_ff <= DW'(req_v2_z) - DW'(req_v0_z);
         prod_ff[0] <= PW'(ay_ff) * PW'(bz_ff);
         prod_ff[1] <= PW'(az_ff) * PW'(by_ff);
         prod_ff[2] <= PW'(az_ff) * PW'(bx_ff);
         prod_ff[3] <= PW'(ax_ff) * PW'(bz_ff);
         prod_ff[4] <= PW'(ax_ff) * PW'(by_ff);
         prod_ff[5] <= PW'(ay_ff) * PW'(bx_ff);
         for (int k = 0; k < 3; k++) begin
            neg3_ff[k] <= cross_w[k][PW];
            mag3_ff[k] <= cross_w[k][PW] ? cross_neg_w[k][MW-1:0] : cross_w[k][MW-1:0];
            sq_ff[k]   <= mag3_ff[k] * mag3_ff[k];
            mag4_ff[k] <= mag3_ff[k];
            mag5_ff[k] <= mag4_ff[k];
         end
         neg4_ff <= neg3_ff;
         neg5_ff <= neg4_ff;
         sum_ff  <= SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
         deg5_ff <= (mag4_ff[0] | mag4_ff[1] | mag4_ff[2]) == '0;
      end
   end

   // square root chain
   logic                 sq_vld  [RW+1];
   logic [SW-1:0]        sq_rad  [RW+1];
   logic [RW+1:0]        sq_rem  [RW+1];
   logic [RW-1:0]        sq_root [RW+1];
   logic [SQ_SIDE-1:0]   sq_side [RW+1];

   assign sq_vld[0]  = fv_ff[4];
   assign sq_rad[0]  = sum_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_side[0] = {mag5_ff[2], mag5_ff[1], mag5_ff[0], neg5_ff, deg5_ff};

   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      ctl_type cell_ctl;

      // hold enable and incoming valid
      assign cell_ctl = {en, sq_vld[i]};

      tfn_sqrt_cell #(.RW(RW), .SIDE_W(SQ_SIDE)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl),
         .rad_in   (sq_rad[i]),
         .rem_in   (sq_rem[i]),
         .root_in  (sq_root[i]),
         .side_in  (sq_side[i]),
         .vld_out  (sq_vld[i+1]),
         .rad_out  (sq_rad[i+1]),
         .rem_out  (sq_rem[i+1]),
         .root_out (sq_root[i+1]),
         .side_out (sq_side[i+1])
      );
   end

   // divider chain, remainders start at the cross magnitudes
   logic                 dv_vld  [QW+1];
   logic [RW-1:0]        dv_div  [QW+1];
   logic [2:0][RW:0]     dv_r    [QW+1];
   logic [2:0][QW-1:0]   dv_q    [QW+1];
   logic [DV_SIDE-1:0]   dv_side [QW+1];
   logic [SQ_SIDE-1:0]   sq_last;

   assign sq_last    = sq_side[RW];
   assign dv_vld[0]  = sq_vld[RW];
   assign dv_div[0]  = sq_root[RW];
   assign dv_side[0] = sq_last[3:0];
   assign dv_q[0]    = '0;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dv_r[0][k] = (RW+1)'(sq_last[4 + k*MW +: MW]);
      end
   end

   for (genvar i = 0; i < QW; i++) begin : g_div
      ctl_type cell_ctl;

      // hold enable and incoming valid
      assign cell_ctl = {en, dv_vld[i]};

      tfn_div_cell #(.RW(RW), .QW(QW), .SIDE_W(DV_SIDE)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl),
         .div_in   (dv_div[i]),
         .r_in     (dv_r[i]),
         .q_in     (dv_q[i]),
         .side_in  (dv_side[i]),
         .vld_out  (dv_vld[i+1]),
         .div_out  (dv_div[i+1]),
         .r_out    (dv_r[i+1]),
         .q_out    (dv_q[i+1]),
         .side_out (dv_side[i+1])
      );
   end

   // apply signs and the degenerate case
   logic [OW-1:0] comp_w [3];
   logic [OW-1:0] qext_w [3];
   logic          last_deg;
   assign last_deg = dv_side[QW][0];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         qext_w[k] = OW'(dv_q[QW][k]);
         if (last_deg) begin
            comp_w[k] = '0;
         end else if (dv_side[QW][1+k]) begin
            comp_w[k] = -qext_w[k];
         end else begin
            comp_w[k] = qext_w[k];
         end
      end
   end
   assign last_res = {comp_w[0], comp_w[1], comp_w[2], last_deg};

   // output register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || !rsp_stall) begin
         if (skid_vld_ff) begin
            out_ff      <= skid_ff;
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_ff     <= last_res;
            out_vld_ff <= dv_vld[QW];
         end
      end else if (dv_vld[QW] && en) begin
         skid_ff     <= last_res;
         skid_vld_ff <= 1'b1;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_normal_x   = out_ff[3*OW -: OW];
   assign rsp_normal_y   = out_ff[2*OW -: OW];
   assign rsp_normal_z   = out_ff[OW -: OW];
   assign rsp_degenerate = out_ff[0];

endmodule

/* design/tfn_checker.sv */
// tfn_checker: port-level checks of the facet normal unit, bound to the top level
// depends on triangle_facet_normal_unit_top_macros.svh
`include "triangle_facet_normal_unit_top_macros.svh"

module tfn_checker #(
   parameter int NORMAL_FRAC_BITS = 14
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_x,
   input logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_y,
   input logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_z,
   input logic                               rsp_degenerate
);
   localparam int LIM = 1 << NORMAL_FRAC_BITS;

   // stalled result holds
   `TFN_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_normal_x) && $stable(rsp_normal_y) && $stable(rsp_normal_z) && $stable(rsp_degenerate), "stalled result changed")

   // degenerate means zero normal
   `TFN_ASSERT_SAME(a_deg_zero, clock, reset, rsp_valid && rsp_degenerate, rsp_normal_x == 0 && rsp_normal_y == 0 && rsp_normal_z == 0, "degenerate with nonzero normal")

   // a real triangle never gives an all-zero normal
   `TFN_ASSERT_SAME(a_nonzero, clock, reset, rsp_valid && !rsp_degenerate, rsp_normal_x != 0 || rsp_normal_y != 0 || rsp_normal_z != 0, "zero normal without degenerate")

   // components stay within unit range
   `TFN_ASSERT_SAME(a_range, clock, reset, rsp_valid, rsp_normal_x <= LIM && rsp_normal_x >= -LIM && rsp_normal_y <= LIM && rsp_normal_y >= -LIM && rsp_normal_z <= LIM && rsp_normal_z >= -LIM, "normal component out of range")

   // reset empties the output
   `TFN_ASSERT_NEXT(a_reset, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

endmodule

bind triangle_facet_normal_unit_top tfn_checker #(
   .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
) u_tfn_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_normal_x   (rsp_normal_x),
   .rsp_normal_y   (rsp_normal_y),
   .rsp_normal_z   (rsp_normal_z),
   .rsp_degenerate (rsp_degenerate)
);
